// ===== hdl/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types, constants and lookup tables of the smoothed derivative filter.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int MAX_HALF    = 16;
  localparam int WIN_DEPTH   = 2 * MAX_HALF + 1;
  localparam int COUNT_MAX   = 63;
  localparam int SCALE_MUL   = 10 * 256;
  localparam int SLOPE_MAX   = 131071;
  localparam int SLOPE_MIN   = -131072;
  localparam int RECIP_SHIFT = 17;
  localparam int DIV_STEPS   = 28;
  localparam int ACC_BOUND   = 2 * 128 * (MAX_HALF * (MAX_HALF + 1) / 2);
  localparam int CMD_DEPTH   = 4;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);

  typedef struct packed {
    logic signed [7:0] sample;
    logic [4:0]        nr;
    logic              emit;
    logic              calc;
    logic [4:0]        zeros;
    logic              last;
  } sdf_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_SCALE,
    ST_DIV,
    ST_FIX,
    ST_EMIT,
    ST_TRAIL
  } sdf_back_state_t;

  // ceil(2^17 / n): exact truncating division of values below 4096 by n
  function automatic logic [17:0] sdf_recip(input logic [4:0] nr);
    logic [17:0] r;
    case (nr)
      5'd1:    r = 18'd131072;
      5'd2:    r = 18'd65536;
      5'd3:    r = 18'd43691;
      5'd4:    r = 18'd32768;
      5'd5:    r = 18'd26215;
      5'd6:    r = 18'd21846;
      5'd7:    r = 18'd18725;
      5'd8:    r = 18'd16384;
      5'd9:    r = 18'd14564;
      5'd10:   r = 18'd13108;
      5'd11:   r = 18'd11916;
      5'd12:   r = 18'd10923;
      5'd13:   r = 18'd10083;
      5'd14:   r = 18'd9363;
      5'd15:   r = 18'd8739;
      5'd16:   r = 18'd8192;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

  // sum of k*k over k = -n..n
  function automatic logic [11:0] sdf_sum_sq(input logic [4:0] nr);
    logic [11:0] s;
    case (nr)
      5'd1:    s = 12'd2;
      5'd2:    s = 12'd10;
      5'd3:    s = 12'd28;
      5'd4:    s = 12'd60;
      5'd5:    s = 12'd110;
      5'd6:    s = 12'd182;
      5'd7:    s = 12'd280;
      5'd8:    s = 12'd408;
      5'd9:    s = 12'd570;
      5'd10:   s = 12'd770;
      5'd11:   s = 12'd1012;
      5'd12:   s = 12'd1300;
      5'd13:   s = 12'd1638;
      5'd14:   s = 12'd2030;
      5'd15:   s = 12'd2480;
      5'd16:   s = 12'd2992;
      default: s = 12'd2;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/sdf_front.sv =====
// ----------------------------------------------------------------------------
// sdf_front
// Holds the half window register and the position count; classifies each
// accepted sample into a command for the back end.
// ----------------------------------------------------------------------------
module sdf_front
  import sdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       push,
  input  logic [7:0] in_sample,
  input  logic       in_last_sample,
  input  logic       cmd_full,
  output logic       cmd_push,
  output sdf_cmd_t   cmd
);

  logic [4:0] half_r;
  logic [4:0] half_nxt;
  logic [5:0] count_r;
  logic [5:0] count_nxt;
  logic [4:0] nr;
  logic [5:0] n;

  always_comb begin
    if (half_r == 5'd0) begin
      nr = 5'd1;
    end else if (half_r > 5'(MAX_HALF)) begin
      nr = 5'(MAX_HALF);
    end else begin
      nr = half_r;
    end
    n = (count_r < 6'(COUNT_MAX)) ? count_r + 6'd1 : count_r;

    cmd_push   = push && !cmd_full;
    cmd.sample = signed'(in_sample);
    cmd.nr     = nr;
    cmd.emit   = n >= (6'(nr) + 6'd1);
    cmd.calc   = n >= {nr, 1'b1};
    cmd.last   = in_last_sample;
    if (!in_last_sample) begin
      cmd.zeros = 5'd0;
    end else if (n < 6'(nr)) begin
      cmd.zeros = n[4:0];
    end else begin
      cmd.zeros = nr;
    end

    half_nxt  = cfg_we ? cfg_wdata : half_r;
    count_nxt = count_r;
    if (cmd_push) begin
      count_nxt = in_last_sample ? 6'd0 : n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= 5'd5;
      count_r <= 6'd0;
    end else begin
      half_r  <= half_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/sdf_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// sdf_cmd_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module sdf_cmd_fifo
  import sdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  sdf_cmd_t wr_cmd,
  output logic     full,
  input  logic     rd_en,
  output sdf_cmd_t rd_cmd,
  output logic     not_empty
);

  sdf_cmd_t             mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r;
  logic [CMD_PTR_W-1:0] wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r;
  logic [CMD_PTR_W-1:0] rd_ptr_nxt;
  logic [CMD_PTR_W:0]   fill_r;
  logic [CMD_PTR_W:0]   fill_nxt;
  logic                 do_wr;
  logic                 do_rd;

  always_comb begin
    full       = fill_r == (CMD_PTR_W + 1)'(CMD_DEPTH);
    not_empty  = fill_r != '0;
    rd_cmd     = mem_r[rd_ptr_r];
    do_wr      = wr_en && !full;
    do_rd      = rd_en && not_empty;
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_wr && !do_rd) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== hdl/sdf_back.sv =====
// ----------------------------------------------------------------------------
// sdf_back
// Keeps the sample window, walks the taps through a three-stage tap pipeline,
// scales and divides the sum, and hands results to the output register.
// ----------------------------------------------------------------------------
module sdf_back
  import sdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  sdf_cmd_t           cmd,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [17:0] out_slope,
  output logic               out_last_result
);

  sdf_back_state_t   state_r;
  sdf_back_state_t   state_nxt;
  logic signed [7:0] win_r [WIN_DEPTH];
  logic signed [7:0] win_nxt [WIN_DEPTH];
  logic signed [7:0] wk_r [WIN_DEPTH];
  logic signed [7:0] wk_nxt [WIN_DEPTH];
  logic signed [5:0] k_r;
  logic signed [5:0] k_nxt;
  logic [5:0]        tap_cnt_r;
  logic [5:0]        tap_cnt_nxt;
  logic              v0_r;
  logic              v0_nxt;
  logic              v1_r;
  logic              v1_nxt;
  logic signed [12:0] kd0_r;
  logic signed [12:0] kd0_nxt;
  logic signed [12:0] kd1_r;
  logic signed [12:0] kd1_nxt;
  logic [11:0]       q1_r;
  logic [11:0]       q1_nxt;
  logic signed [17:0] acc_r;
  logic signed [17:0] acc_nxt;
  logic [17:0]       recip_r;
  logic [17:0]       recip_nxt;
  logic [11:0]       dvs_r;
  logic [11:0]       dvs_nxt;
  logic              neg_r;
  logic              neg_nxt;
  logic [27:0]       dq_r;
  logic [27:0]       dq_nxt;
  logic [11:0]       rem_r;
  logic [11:0]       rem_nxt;
  logic [4:0]        div_cnt_r;
  logic [4:0]        div_cnt_nxt;
  logic signed [17:0] value_r;
  logic signed [17:0] value_nxt;
  logic [4:0]        zeros_r;
  logic [4:0]        zeros_nxt;
  logic              last_r;
  logic              last_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic signed [17:0] out_slope_r;
  logic signed [17:0] out_slope_nxt;
  logic              out_last_r;
  logic              out_last_nxt;

  logic              out_free;
  logic [12:0]       mag0;
  logic [29:0]       div_prod;
  logic signed [17:0] q_signed;
  logic [17:0]       acc_mag;
  logic [29:0]       scaled;
  logic [12:0]       trial;

  assign empty           = !out_valid_r;
  assign out_slope       = out_slope_r;
  assign out_last_result = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    wk_nxt        = wk_r;
    k_nxt         = k_r;
    tap_cnt_nxt   = tap_cnt_r;
    recip_nxt     = recip_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    value_nxt     = value_r;
    zeros_nxt     = zeros_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_slope_nxt = out_slope_r;
    out_last_nxt  = out_last_r;
    cmd_pop       = 1'b0;
    out_free      = !out_valid_r || pop;

    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    // tap pipeline: product, truncated quotient, accumulate
    mag0     = kd0_r[12] ? 13'(-kd0_r) : 13'(kd0_r);
    div_prod = 30'(mag0[11:0]) * 30'(recip_r);
    q1_nxt   = div_prod[RECIP_SHIFT +: 12];
    kd1_nxt  = kd0_r;
    v1_nxt   = v0_r;
    v0_nxt   = 1'b0;
    kd0_nxt  = kd0_r;
    q_signed = signed'({6'd0, q1_r});
    acc_nxt  = acc_r;
    if (v1_r) begin
      acc_nxt = acc_r + 18'(kd1_r) - (kd1_r[12] ? -q_signed : q_signed);
    end

    acc_mag = acc_r[17] ? 18'(-acc_r) : 18'(acc_r);
    scaled  = 30'(acc_mag) * 30'(SCALE_MUL);
    trial   = {rem_r, dq_r[27]};

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          win_nxt[0] = cmd.sample;
          for (int i = 1; i < WIN_DEPTH; i++) begin
            win_nxt[i] = win_r[i-1];
          end
          recip_nxt = sdf_recip(cmd.nr);
          dvs_nxt   = sdf_sum_sq(cmd.nr);
          zeros_nxt = cmd.zeros;
          last_nxt  = cmd.last;
          acc_nxt   = '0;
          if (cmd.calc) begin
            wk_nxt      = win_nxt;
            k_nxt       = signed'({1'b0, cmd.nr});
            tap_cnt_nxt = {cmd.nr, 1'b1};
            state_nxt   = ST_WALK;
          end else if (cmd.emit) begin
            value_nxt = '0;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_TRAIL;
          end
        end
      end
      ST_WALK: begin
        v0_nxt  = 1'b1;
        kd0_nxt = 13'(k_r) * 13'(wk_r[0]);
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          wk_nxt[i] = wk_r[i+1];
        end
        wk_nxt[WIN_DEPTH-1] = '0;
        k_nxt       = k_r - 6'sd1;
        tap_cnt_nxt = tap_cnt_r - 6'd1;
        if (tap_cnt_r == 6'd1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v0_r && !v1_r) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        neg_nxt     = acc_r[17];
        dq_nxt      = scaled[27:0];
        rem_nxt     = '0;
        div_cnt_nxt = 5'(DIV_STEPS);
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = 12'(trial - {1'b0, dvs_r});
          dq_nxt  = {dq_r[26:0], 1'b1};
        end else begin
          rem_nxt = trial[11:0];
          dq_nxt  = {dq_r[26:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == 5'd1) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (neg_r) begin
          if (dq_r > 28'(-SLOPE_MIN)) begin
            value_nxt = 18'(SLOPE_MIN);
          end else begin
            value_nxt = signed'(18'd0 - dq_r[17:0]);
          end
        end else begin
          if (dq_r > 28'(SLOPE_MAX)) begin
            value_nxt = 18'(SLOPE_MAX);
          end else begin
            value_nxt = signed'(dq_r[17:0]);
          end
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slope_nxt = value_r;
          out_last_nxt  = last_r && (zeros_r == 5'd0);
          state_nxt     = ST_TRAIL;
        end
      end
      ST_TRAIL: begin
        if (zeros_r == 5'd0) begin
          if (last_r) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
              win_nxt[i] = '0;
            end
          end
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slope_nxt = '0;
          out_last_nxt  = last_r && (zeros_r == 5'd1);
          zeros_nxt     = zeros_r - 5'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      v0_r        <= v0_nxt;
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_r        <= wk_nxt;
    k_r         <= k_nxt;
    tap_cnt_r   <= tap_cnt_nxt;
    kd0_r       <= kd0_nxt;
    kd1_r       <= kd1_nxt;
    q1_r        <= q1_nxt;
    acc_r       <= acc_nxt;
    recip_r     <= recip_nxt;
    dvs_r       <= dvs_nxt;
    neg_r       <= neg_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    value_r     <= value_nxt;
    zeros_r     <= zeros_nxt;
    last_r      <= last_nxt;
    out_slope_r <= out_slope_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_tap_pipe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r || v1_r) |-> (state_r == ST_WALK || state_r == ST_DRAIN))
    else $error("tap pipeline busy outside the tap walk");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dvs_r != 12'd0))
    else $error("zero divisor during division");

  a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCALE) |-> (acc_r <= 18'(ACC_BOUND) && acc_r >= -18'(ACC_BOUND)))
    else $error("tap sum out of range");

  a_result_leaves_by_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(pop))
    else $error("result dropped without a transfer");

endmodule

// ===== hdl/smoothed_derivative_filter_unit.sv =====
// ----------------------------------------------------------------------------
// smoothed_derivative_filter_unit
// Smoothed derivative of a sampled curve, 8 fraction bits, saturated.
//
//   channel  handshake       payload                       direction
//   input    push / full     in_sample, in_last_sample     in
//   result   empty / pop     out_slope, out_last_result    out
//   config   cfg_we          cfg_wdata (window half)       in
//
// The time a computed result takes is set by the tap walk (one tap a cycle
// through a three-stage pipeline) and the 28-step divider.
// Up to four commands queue ahead of the back end while it works or stalls.
// Reset is synchronous, active low; it clears the window and position count.
// ----------------------------------------------------------------------------
module smoothed_derivative_filter_unit
  import sdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               push,
  output logic               full,
  input  logic signed [7:0]  in_sample,
  input  logic               in_last_sample,
  output logic               empty,
  input  logic               pop,
  output logic signed [17:0] out_slope,
  output logic               out_last_result
);

  sdf_cmd_t front_cmd;
  sdf_cmd_t back_cmd;
  logic     front_push;
  logic     back_pop;
  logic     back_valid;

  sdf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .cmd_full       (full),
    .cmd_push       (front_push),
    .cmd            (front_cmd)
  );

  sdf_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (front_push),
    .wr_cmd    (front_cmd),
    .full      (full),
    .rd_en     (back_pop),
    .rd_cmd    (back_cmd),
    .not_empty (back_valid)
  );

  sdf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (back_valid),
    .cmd             (back_cmd),
    .cmd_pop         (back_pop),
    .pop             (pop),
    .empty           (empty),
    .out_slope       (out_slope),
    .out_last_result (out_last_result)
  );

endmodule

// ===== test/smoothed_derivative_filter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// smoothed_derivative_filter_unit_tb
// Self-checking bench for the smoothed derivative filter. A behavioural
// predictor follows every accepted sample and queues the slopes it expects.
// A monitor compares each popped result field by field. Directed curves cover
// the sample extremes, clamped and changed window halves and short curves.
// A long receiver hold-off fills the block up; random curves then run under
// three idling mixes.
// ----------------------------------------------------------------------------
module smoothed_derivative_filter_unit_tb
  import sdf_pkg::*;
();

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 80;
  localparam int GAIN        = 2560;

  typedef struct packed {
    logic signed [17:0] slope;
    logic               last_res;
  } slope_rec_t;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               cfg_we          = 1'b0;
  logic [4:0]         cfg_wdata       = 5'd0;
  logic               push            = 1'b0;
  logic               full;
  logic signed [7:0]  in_sample       = 8'sd0;
  logic               in_last_sample  = 1'b0;
  logic               empty;
  logic               pop             = 1'b0;
  logic signed [17:0] out_slope;
  logic               out_last_result;

  logic signed [7:0]  tap_hist [WIN_DEPTH];
  logic [5:0]         curve_pos;
  logic [4:0]         cur_half = 5'd5;
  slope_rec_t         slope_q [$];

  int send_idle   = 0;
  int recv_idle   = 0;
  int hold_req    = 0;
  int hold_left   = 0;
  int err_count   = 0;
  int stall_count = 0;

  smoothed_derivative_filter_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .push            (push),
    .full            (full),
    .in_sample       (in_sample),
    .in_last_sample  (in_last_sample),
    .empty           (empty),
    .pop             (pop),
    .out_slope       (out_slope),
    .out_last_result (out_last_result)
  );

  always #5 clk = ~clk;

  function automatic int unsigned active_half();
    if (cur_half == 5'd0) return 1;
    if (cur_half > MAX_HALF) return MAX_HALF;
    return cur_half;
  endfunction

  function automatic logic signed [17:0] clamp_slope(input longint v);
    if (v > SLOPE_MAX) v = SLOPE_MAX;
    if (v < SLOPE_MIN) v = SLOPE_MIN;
    return v[17:0];
  endfunction

  function automatic longint slope_at(input int unsigned nr);
    longint acc;
    longint kd;
    longint nn;
    longint k;
    int     off;
    nn  = nr;
    acc = 0;
    for (k = -nn; k <= nn; k++) begin
      off = int'(nn - k);
      kd  = k * longint'(tap_hist[off]);
      acc += kd - kd / nn;
    end
    return (acc * GAIN) / (nn * (nn + 1) * (2 * nn + 1) / 3);
  endfunction

  task automatic predict_sample(input logic signed [7:0] s, input logic lst);
    int unsigned nr;
    int unsigned n;
    int unsigned extra;
    int          total;
    int          idx;
    int          i;
    logic        has_main;
    longint      v;
    slope_rec_t  r;
    nr = active_half();
    for (i = WIN_DEPTH - 1; i > 0; i--) tap_hist[i] = tap_hist[i - 1];
    tap_hist[0] = s;
    if (curve_pos < COUNT_MAX) curve_pos = curve_pos + 6'd1;
    n        = curve_pos;
    has_main = (n >= nr + 1);
    extra    = lst ? ((n < nr) ? n : nr) : 0;
    total    = int'(has_main) + extra;
    for (idx = 0; idx < total; idx++) begin
      v = 0;
      if (idx == 0 && has_main && n >= 2 * nr + 1) v = slope_at(nr);
      r.slope    = clamp_slope(v);
      r.last_res = lst && (idx == total - 1);
      slope_q.push_back(r);
    end
    if (lst) begin
      for (i = 0; i < WIN_DEPTH; i++) tap_hist[i] = 8'sd0;
      curve_pos = 6'd0;
    end
  endtask

  task report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  // predictor and checker share one process so queue order is fixed
  always @(posedge clk) begin
    slope_rec_t want;
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) tap_hist[i] = 8'sd0;
      curve_pos = 6'd0;
      cur_half  = 5'd5;
    end else begin
      if (cfg_we) cur_half = cfg_wdata;
      if (push && !full) predict_sample(in_sample, in_last_sample);
      if (pop && !empty) begin
        if (slope_q.size() == 0) begin
          report_mismatch("result with none pending", out_slope, 0);
        end else begin
          want = slope_q.pop_front();
          if (out_slope !== want.slope) report_mismatch("slope", out_slope, want.slope);
          if (out_last_result !== want.last_res)
            report_mismatch("last_result", out_last_result, want.last_res);
        end
      end
      if ((push && !full) || (pop && !empty)) stall_count = 0;
      else stall_count++;
    end
  end

  // receiver: random idling, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin
    while (stall_count < STALL_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input logic signed [7:0] s, input logic lst);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    in_sample      <= s;
    in_last_sample <= lst;
    push           <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (slope_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_half(input logic [4:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [4:0] pick_half();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 5'd0;
    if (r == 1) return 5'd16;
    if (r == 2) return 5'($urandom_range(17, 31));
    if (r < 5) return 5'($urandom_range(9, 15));
    return 5'($urandom_range(1, 8));
  endfunction

  function automatic logic signed [7:0] curve_sample(input int kind, input int i,
                                                     input int base, input int slope);
    int v;
    case (kind)
      0: v = int'($urandom_range(0, 255)) - 128;
      1: v = base + slope * i + int'($urandom_range(0, 6)) - 3;
      default: v = $urandom_range(0, 1) ? 127 : -128;
    endcase
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v[7:0];
  endfunction

  task automatic test_reset_default();
    send_item(8'sd77, 1'b1);
  endtask

  task automatic test_sample_extremes();
    write_half(5'd2);
    send_item(-8'sd128, 1'b0);
    send_item(-8'sd128, 1'b0);
    send_item(8'sd0, 1'b0);
    send_item(8'sd127, 1'b0);
    send_item(8'sd127, 1'b0);
    send_item(8'sd127, 1'b1);
    send_item(8'sd127, 1'b0);
    send_item(8'sd127, 1'b0);
    send_item(8'sd0, 1'b0);
    send_item(-8'sd128, 1'b0);
    send_item(-8'sd128, 1'b1);
  endtask

  task automatic test_half_clamped();
    write_half(5'd0);
    send_item(-8'sd128, 1'b0);
    send_item(8'sd127, 1'b0);
    send_item(8'sd0, 1'b1);
    write_half(5'd31);
    send_item(8'sd1, 1'b0);
    send_item(-8'sd1, 1'b0);
    send_item(8'sd64, 1'b0);
    send_item(-8'sd64, 1'b1);
  endtask

  task automatic test_half_change_mid_curve();
    write_half(5'd3);
    send_item(8'sd10, 1'b0);
    send_item(8'sd20, 1'b0);
    send_item(8'sd40, 1'b0);
    send_item(8'sd80, 1'b0);
    write_half(5'd1);
    send_item(8'sd100, 1'b0);
    send_item(8'sd120, 1'b1);
  endtask

  task automatic test_fill_and_stall();
    int i;
    write_half(5'd2);
    send_idle = 0;
    hold_req  = 500;
    for (i = 0; i < 40; i++) send_item(curve_sample(0, i, 0, 0), i == 39);
    wait_drained();
  endtask

  task automatic test_random_curves(input int budget);
    int sent;
    int len;
    int kind;
    int split;
    int base;
    int slope;
    int i;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 3) == 0) write_half(pick_half());
      if ($urandom_range(0, 15) == 0) len = 70;
      else len = $urandom_range(1, 2 * active_half() + 10);
      kind  = $urandom_range(0, 4) % 3;
      base  = int'($urandom_range(0, 255)) - 128;
      slope = int'($urandom_range(0, 16)) - 8;
      split = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : 0;
      for (i = 0; i < len; i++) begin
        if (split != 0 && i == split) write_half(pick_half());
        send_item(curve_sample(kind, i, base, slope), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_default();
    test_sample_extremes();
    test_half_clamped();
    test_half_change_mid_curve();
    test_fill_and_stall();
    send_idle = 17;
    recv_idle = 54;
    test_random_curves(75);
    send_idle = 54;
    recv_idle = 17;
    test_random_curves(75);
    send_idle = 0;
    recv_idle = 0;
    test_random_curves(75);
    wait_drained();
    repeat (100) @(posedge clk);
    if (slope_q.size() != 0) report_mismatch("results never arrived", slope_q.size(), 0);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
